// File: src/pblr_pkg.sv
package pblr_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned NowW      = 64;
  localparam int unsigned WantW     = 7;
  localparam int unsigned AvgW      = 24;
  localparam int unsigned CntOutW   = 7;
  localparam int unsigned PeriodW   = 32;
  localparam int unsigned DividendW = 64;
  localparam int unsigned DivisorW  = 32;
  localparam int unsigned DivCntW   = $clog2(DividendW);

  localparam logic [SampleW-1:0] SampleMax     = 16'hFFFF;
  localparam logic [PeriodW-1:0] PeriodDefault = 32'd100000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SNAP  = 2'd1,
    OP_STATS = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_SAMPLE = 3'd1,
    KIND_EMPTY  = 3'd2,
    KIND_STATS  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef struct packed {
    op_e                opcode;
    logic [SampleW-1:0] latency_ms;
    logic [NowW-1:0]    now_us;
    logic [WantW-1:0]   want_count;
  } pblr_in_t;

  typedef struct packed {
    kind_e              kind;
    logic [SampleW-1:0] sample_ms;
    logic               is_last;
    logic [SampleW-1:0] min_ms;
    logic [SampleW-1:0] max_ms;
    logic [SampleW-1:0] last_ms;
    logic [AvgW-1:0]    avg_q8;
    logic [CntOutW-1:0] stored_count;
  } pblr_out_t;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DividendW-1:0] quot;
    logic [DivisorW-1:0]  rem;
  } div_rsp_t;

endpackage

// File: src/pblr_div.sv
module pblr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pblr_pkg::div_req_t req_i,
  output pblr_pkg::div_rsp_t rsp_o
);
  import pblr_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dsr_q, dsr_d;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DividendW-2:0], ge};
      rem_d = ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o = '{done: done_q, quot: quo_q, rem: rem_q};

endmodule

// File: src/peak_binned_latency_ring.sv
// channel | dir | handshake             | beat
// cfg     | in  | cfg_valid_i/ready_o   | bin period in microseconds (32 bit)
// in      | in  | in_valid_i/in_stall_o | pblr_in_t: opcode, latency, timestamp, count
// out     | out | out_valid_o/stall_i   | pblr_out_t: kind, sample, last flag, statistics
//
// one item at a time; in_stall_o is high from acceptance until its last result is queued
// add: the 64-step shared bit-serial divider finds k bins; min(k, RingDepth) ring writes
// snapshot: per sample S_SREAD, registered read port, S_SDATA, S_RESP, plus output stalls
// stats: one ring read per cycle over the stored entries, then the same divider
// async active-low reset clears control state only; the ring is not swept after reset
module peak_binned_latency_ring #(
  parameter int unsigned RingDepth = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pblr_pkg::pblr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pblr_pkg::pblr_out_t out_data_o
);
  import pblr_pkg::*;

  localparam int unsigned AW   = $clog2(RingDepth);
  localparam int unsigned CW   = $clog2(RingDepth + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned SumW = SampleW + CW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ADIV  = 11'b00000000010,
    S_AWAIT = 11'b00000000100,
    S_FILL  = 11'b00000001000,
    S_FOLD  = 11'b00000010000,
    S_SREAD = 11'b00000100000,
    S_SDATA = 11'b00001000000,
    S_TWALK = 11'b00010000000,
    S_TDIVS = 11'b00100000000,
    S_TWAIT = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_e;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    logic [AW-1:0] res;
    res = (idx == AW'(RingDepth - 1)) ? '0 : idx + 1'b1;
    return res;
  endfunction

  state_e               state_q, state_d;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [SampleW-1:0]   peak_q, peak_d;
  logic                 peak_valid_q, peak_valid_d;
  logic                 mark_valid_q, mark_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [PeriodW-1:0]   period_q, period_d;
  logic                 more_q, more_d;
  logic                 acc_vld_q, acc_vld_d;

  logic [NowW-1:0]      mark_q, mark_d;
  logic [NowW-1:0]      elapsed_q, elapsed_d;
  logic [NowW-1:0]      kp_q, kp_d;
  logic [SampleW-1:0]   ms_q, ms_d;
  logic [SampleW-1:0]   last_q, last_d;
  logic [SampleW-1:0]   fill_val_q, fill_val_d;
  logic [CW-1:0]        fill_left_q, fill_left_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic [CW-1:0]        rd_left_q, rd_left_d;
  logic [CW-1:0]        acc_left_q, acc_left_d;
  logic [SampleW-1:0]   min_q, min_d;
  logic [SampleW-1:0]   max_q, max_d;
  logic [SumW-1:0]      sum_q, sum_d;
  pblr_out_t            res_q, res_d;
  pblr_out_t            out_q, out_d;

  logic [SampleW-1:0]   ring_q [RingDepth];
  logic [SampleW-1:0]   rd_data_q;
  logic                 ring_we;
  logic                 ring_re;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 in_acc;
  logic                 out_free;
  logic [PeriodW-1:0]   period_eff;
  logic [CW-1:0]        snap_n;
  logic [CW-1:0]        back_n;
  logic [SW-1:0]        sb_sum;
  logic [AW-1:0]        sb_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign period_eff  = (period_q == '0) ? PeriodW'(1) : period_q;

  // oldest index of the newest back_n entries
  assign snap_n = (in_data_i.want_count < WantW'(count_q)) ? CW'(in_data_i.want_count)
                                                           : count_q;
  assign back_n = (in_data_i.opcode == OP_SNAP) ? snap_n : count_q;
  assign sb_sum = SW'(head_q) + SW'(RingDepth) - SW'(back_n);
  assign sb_idx = (sb_sum >= SW'(RingDepth)) ? AW'(sb_sum - SW'(RingDepth)) : AW'(sb_sum);

  pblr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    peak_d       = peak_q;
    peak_valid_d = peak_valid_q;
    mark_valid_d = mark_valid_q;
    out_valid_d  = out_valid_q;
    period_d     = period_q;
    more_d       = more_q;
    acc_vld_d    = 1'b0;
    mark_d       = mark_q;
    elapsed_d    = elapsed_q;
    kp_d         = kp_q;
    ms_d         = ms_q;
    last_d       = last_q;
    fill_val_d   = fill_val_q;
    fill_left_d  = fill_left_q;
    rd_idx_d     = rd_idx_q;
    rd_left_d    = rd_left_q;
    acc_left_d   = acc_left_q;
    min_d        = min_q;
    max_d        = max_q;
    sum_d        = sum_q;
    res_d        = res_q;
    out_d        = out_q;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    div_req      = '{start: 1'b0, dividend: elapsed_q, divisor: period_eff};

    if (cfg_valid_i) begin
      period_d = cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          more_d       = 1'b0;
          res_d        = '0;
          res_d.is_last = 1'b1;
          rd_idx_d     = sb_idx;
          unique case (in_data_i.opcode)
            OP_ADD: begin
              ms_d = in_data_i.latency_ms;
              if (mark_valid_q) begin
                elapsed_d = in_data_i.now_us - mark_q;
              end else begin
                mark_d       = in_data_i.now_us;
                mark_valid_d = 1'b1;
                elapsed_d    = '0;
              end
              state_d = S_ADIV;
            end
            OP_SNAP: begin
              rd_left_d = snap_n;
              if (snap_n == '0) begin
                res_d.kind = KIND_EMPTY;
                state_d    = S_RESP;
              end else begin
                state_d = S_SREAD;
              end
            end
            OP_STATS: begin
              res_d.kind = KIND_STATS;
              rd_left_d  = count_q;
              acc_left_d = count_q;
              min_d      = SampleMax;
              max_d      = '0;
              sum_d      = '0;
              state_d    = (count_q == '0) ? S_RESP : S_TWALK;
            end
            OP_CLEAR: begin
              head_d       = '0;
              count_d      = '0;
              peak_d       = '0;
              peak_valid_d = 1'b0;
              mark_valid_d = 1'b0;
              res_d.kind   = KIND_CLEAR;
              state_d      = S_RESP;
            end
          endcase
        end
      end
      S_ADIV: begin
        div_req.start = 1'b1;
        state_d       = S_AWAIT;
      end
      S_AWAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot == '0) begin
            state_d = S_FOLD;
          end else begin
            // each filled bin takes the held peak if valid, else the newest stored value, or the new sample
            fill_val_d  = peak_valid_q ? peak_q : ((count_q != '0) ? last_q : ms_q);
            fill_left_d = (div_rsp.quot >= DividendW'(RingDepth)) ? CW'(RingDepth)
                                                                  : div_rsp.quot[CW-1:0];
            // k * period is elapsed minus the remainder
            kp_d        = elapsed_q - NowW'(div_rsp.rem);
            state_d     = S_FILL;
          end
        end
      end
      S_FILL: begin
        ring_we     = 1'b1;
        head_d      = idx_inc(head_q);
        last_d      = fill_val_q;
        fill_left_d = fill_left_q - 1'b1;
        if (count_q != CW'(RingDepth)) begin
          count_d = count_q + 1'b1;
        end
        if (fill_left_q == CW'(1)) begin
          mark_d       = mark_q + kp_q;
          peak_valid_d = 1'b0;
          state_d      = S_FOLD;
        end
      end
      S_FOLD: begin
        if (!peak_valid_q || (ms_q > peak_q)) begin
          peak_d       = ms_q;
          peak_valid_d = 1'b1;
        end
        res_d.kind = KIND_ADD;
        state_d    = S_RESP;
      end
      S_SREAD: begin
        ring_re  = 1'b1;
        rd_idx_d = idx_inc(rd_idx_q);
        state_d  = S_SDATA;
      end
      S_SDATA: begin
        res_d           = '0;
        res_d.kind      = KIND_SAMPLE;
        res_d.sample_ms = rd_data_q;
        res_d.is_last   = (rd_left_q == CW'(1));
        more_d          = (rd_left_q != CW'(1));
        rd_left_d       = rd_left_q - 1'b1;
        state_d         = S_RESP;
      end
      S_TWALK: begin
        // each ring read is accumulated in the cycle after it is issued
        if (rd_left_q != '0) begin
          ring_re   = 1'b1;
          rd_idx_d  = idx_inc(rd_idx_q);
          rd_left_d = rd_left_q - 1'b1;
          acc_vld_d = 1'b1;
        end
        if (acc_vld_q) begin
          if (rd_data_q < min_q) min_d = rd_data_q;
          if (rd_data_q > max_q) max_d = rd_data_q;
          sum_d      = sum_q + SumW'(rd_data_q);
          acc_left_d = acc_left_q - 1'b1;
          if (acc_left_q == CW'(1)) begin
            state_d = S_TDIVS;
          end
        end
      end
      S_TDIVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = DividendW'({sum_q, 8'h00});
        div_req.divisor  = DivisorW'(count_q);
        state_d          = S_TWAIT;
      end
      S_TWAIT: begin
        if (div_rsp.done) begin
          res_d.min_ms       = min_q;
          res_d.max_ms       = max_q;
          res_d.last_ms      = last_q;
          res_d.avg_q8       = div_rsp.quot[AvgW-1:0];
          res_d.stored_count = CntOutW'(count_q);
          state_d            = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = more_q ? S_SREAD : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      peak_q       <= '0;
      peak_valid_q <= 1'b0;
      mark_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      period_q     <= PeriodDefault;
      more_q       <= 1'b0;
      acc_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      peak_q       <= peak_d;
      peak_valid_q <= peak_valid_d;
      mark_valid_q <= mark_valid_d;
      out_valid_q  <= out_valid_d;
      period_q     <= period_d;
      more_q       <= more_d;
      acc_vld_q    <= acc_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_q      <= mark_d;
    elapsed_q   <= elapsed_d;
    kp_q        <= kp_d;
    ms_q        <= ms_d;
    last_q      <= last_d;
    fill_val_q  <= fill_val_d;
    fill_left_q <= fill_left_d;
    rd_idx_q    <= rd_idx_d;
    rd_left_q   <= rd_left_d;
    acc_left_q  <= acc_left_d;
    min_q       <= min_d;
    max_q       <= max_d;
    sum_q       <= sum_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[head_q] <= fill_val_q;
    end
    if (ring_re) begin
      rd_data_q <= ring_q[rd_idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // head and count move together while the ring is not full
  a_head_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != CW'(RingDepth)) |-> (head_q == count_q[AW-1:0]))
    else $error("ring head out of step with fill count");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == S_AWAIT) || (state_q == S_TWAIT)))
    else $error("divider finished while no one waits for it");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("output beat raised outside the response state");

endmodule

// File: bench/latency_ring_checker.sv
`timescale 1ns / 1ps

module latency_ring_checker #(
  parameter int unsigned RingDepth = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [pblr_pkg::PeriodW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  pblr_pkg::pblr_in_t           in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  pblr_pkg::pblr_out_t          out_data_i,
  output int                           mismatches_o,
  output int                           pending_o
);
  import pblr_pkg::*;

  localparam int unsigned IdxW = $clog2(RingDepth);

  logic [SampleW-1:0] ring [RingDepth];
  int unsigned        head;
  int unsigned        stored;
  logic [SampleW-1:0] peak;
  logic               peak_ok;
  logic [NowW-1:0]    mark;
  logic               mark_ok;
  logic [PeriodW-1:0] period;

  pblr_out_t expected_beats [$];
  pblr_out_t oldest;
  int        beat_count;
  int        mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic logic [IdxW-1:0] slot(input int unsigned pos);
    return IdxW'(pos % RingDepth);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input int idx, input string name,
                             input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("beat %0d %s: got %0h want %0h", idx, name, got, want));
    end
  endtask

  function automatic pblr_out_t make_beat(input kind_e kind, input logic [SampleW-1:0] sample,
                                          input logic last);
    pblr_out_t beat;
    beat           = '0;
    beat.kind      = kind;
    beat.sample_ms = sample;
    beat.is_last   = last;
    return beat;
  endfunction

  function automatic logic [SampleW-1:0] newest_sample();
    if (stored == 0) return '0;
    return ring[slot(head + RingDepth - 1)];
  endfunction

  // close every elapsed bin, then fold the sample into the running peak
  task automatic fold_sample(input logic [SampleW-1:0] ms, input logic [NowW-1:0] now);
    logic [63:0]        span;
    logic [63:0]        elapsed;
    logic [63:0]        nbins;
    logic [SampleW-1:0] fill;
    int unsigned        writes;
    int unsigned        i;
    span = (period == '0) ? 64'd1 : 64'(period);
    if (!mark_ok) begin
      mark    = now;
      mark_ok = 1'b1;
    end
    elapsed = now - mark;
    nbins   = elapsed / span;
    if (nbins != 0) begin
      if (peak_ok) fill = peak;
      else if (stored != 0) fill = newest_sample();
      else fill = ms;
      writes = (nbins < 64'(RingDepth)) ? nbins[31:0] : RingDepth;
      for (i = 0; i < writes; i++) begin
        ring[slot(head)] = fill;
        head             = (head + 1) % RingDepth;
        if (stored < RingDepth) stored++;
      end
      mark    = mark + nbins * span;
      peak_ok = 1'b0;
    end
    if (!peak_ok || ms > peak) begin
      peak    = ms;
      peak_ok = 1'b1;
    end
  endtask

  task automatic compute_beats(input pblr_in_t item);
    int unsigned        n;
    int unsigned        first;
    int unsigned        i;
    logic [SampleW-1:0] s;
    logic [SampleW-1:0] lo;
    logic [SampleW-1:0] hi;
    logic [63:0]        sum;
    logic [63:0]        avg;
    pblr_out_t          beat;
    case (item.opcode)
      OP_ADD: begin
        fold_sample(item.latency_ms, item.now_us);
        expected_beats.push_back(make_beat(KIND_ADD, '0, 1'b1));
      end
      OP_SNAP: begin
        n = (32'(item.want_count) < stored) ? 32'(item.want_count) : stored;
        if (n == 0) begin
          expected_beats.push_back(make_beat(KIND_EMPTY, '0, 1'b1));
        end else begin
          first = (head + RingDepth - n) % RingDepth;
          for (i = 0; i < n; i++) begin
            s = ring[slot(first + i)];
            expected_beats.push_back(make_beat(KIND_SAMPLE, s, i + 1 == n));
          end
        end
      end
      OP_STATS: begin
        lo  = '0;
        hi  = '0;
        avg = '0;
        if (stored != 0) begin
          first = (head + RingDepth - stored) % RingDepth;
          lo    = SampleMax;
          sum   = '0;
          for (i = 0; i < stored; i++) begin
            s = ring[slot(first + i)];
            if (s < lo) lo = s;
            if (s > hi) hi = s;
            sum = sum + 64'(s);
          end
          avg = (sum << 8) / 64'(stored);
        end
        beat              = make_beat(KIND_STATS, '0, 1'b1);
        beat.min_ms       = lo;
        beat.max_ms       = hi;
        beat.last_ms      = newest_sample();
        beat.avg_q8       = avg[AvgW-1:0];
        beat.stored_count = CntOutW'(stored);
        expected_beats.push_back(beat);
      end
      default: begin
        head    = 0;
        stored  = 0;
        peak    = '0;
        peak_ok = 1'b0;
        mark_ok = 1'b0;
        expected_beats.push_back(make_beat(KIND_CLEAR, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period  = PeriodDefault;
      head    = 0;
      stored  = 0;
      peak    = '0;
      peak_ok = 1'b0;
      mark    = '0;
      mark_ok = 1'b0;
      expected_beats.delete();
      beat_count = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("beat %0d kind %0d arrived with nothing expected",
                                    beat_count, out_data_i.kind));
        end else begin
          oldest = expected_beats.pop_front();
          check_field(beat_count, "kind", 64'(out_data_i.kind), 64'(oldest.kind));
          check_field(beat_count, "sample_ms", 64'(out_data_i.sample_ms),
                      64'(oldest.sample_ms));
          check_field(beat_count, "is_last", 64'(out_data_i.is_last), 64'(oldest.is_last));
          check_field(beat_count, "min_ms", 64'(out_data_i.min_ms), 64'(oldest.min_ms));
          check_field(beat_count, "max_ms", 64'(out_data_i.max_ms), 64'(oldest.max_ms));
          check_field(beat_count, "last_ms", 64'(out_data_i.last_ms), 64'(oldest.last_ms));
          check_field(beat_count, "avg_q8", 64'(out_data_i.avg_q8), 64'(oldest.avg_q8));
          check_field(beat_count, "stored_count", 64'(out_data_i.stored_count),
                      64'(oldest.stored_count));
        end
        beat_count++;
      end
      if (in_valid_i && !in_stall_i) compute_beats(in_data_i);
      if (cfg_valid_i && cfg_ready_i) period = cfg_data_i;
      pending_o <= expected_beats.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pblr_pkg::*;

  localparam int unsigned RingDepth     = 64;
  localparam int unsigned ItemsPerPhase = 31;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned QuietLimit    = 5000;
  localparam int unsigned TailCycles    = 200;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [PeriodW-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  pblr_in_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  pblr_out_t          out_data_o;

  int                 mismatches;
  int                 pending;
  int                 quiet = 0;
  int                 hold_seq = 0;
  logic               calm = 1'b0;
  logic [NowW-1:0]    now_cursor;
  logic [PeriodW-1:0] cur_period;

  peak_binned_latency_ring #(
    .RingDepth(RingDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  latency_ring_checker #(
    .RingDepth(RingDepth)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("peak_binned_latency_ring: mismatch");
      $finish;
    end
  end

  // result side: random stall bursts, calm stretches, and one long hold-off on request
  initial begin : receiver
    int hold_seen;
    int hold_left;
    int burst_left;
    int mode_left;
    bit bursty;
    hold_seen  = 0;
    hold_left  = 0;
    burst_left = 0;
    mode_left  = 0;
    bursty     = 1'b1;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        bursty    = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if (bursty && !calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(0, 6);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic pblr_in_t make_item(input op_e op, input logic [SampleW-1:0] lat,
                                         input logic [NowW-1:0] now,
                                         input logic [WantW-1:0] want);
    pblr_in_t item;
    item.opcode     = op;
    item.latency_ms = lat;
    item.now_us     = now;
    item.want_count = want;
    return item;
  endfunction

  task automatic send_item(input pblr_in_t item);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_period(input logic [PeriodW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_period = value;
  endtask

  // mostly adds marching forward in time, with jumps, long gaps and random timestamps
  task automatic next_random(output pblr_in_t item);
    int          roll;
    logic [63:0] span;
    logic [63:0] step;
    item = make_item(OP_ADD, SampleW'($urandom), {$urandom, $urandom},
                     WantW'($urandom_range(0, 64)));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      span = (cur_period == 0) ? 64'd1 : 64'(cur_period);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: step = {$urandom, $urandom} % (span / 2 + 1);
        5, 6, 7: step = span * $urandom_range(1, 4) + ({$urandom, $urandom} % span);
        8: step = span * $urandom_range(5, 90);
        default: step = {$urandom, $urandom} - now_cursor;
      endcase
      now_cursor  = now_cursor + step;
      item.now_us = now_cursor;
      case ($urandom_range(0, 9))
        0: item.latency_ms = '0;
        1: item.latency_ms = SampleMax;
        2, 3: item.latency_ms = SampleW'($urandom_range(0, 300));
        default: item.latency_ms = SampleW'($urandom);
      endcase
    end else if (roll < 75) begin
      item.opcode     = OP_SNAP;
      item.want_count = ($urandom_range(0, 3) == 0) ? WantW'($urandom_range(40, 64))
                                                    : WantW'($urandom_range(0, 12));
    end else if (roll < 92) begin
      item.opcode = OP_STATS;
    end else begin
      item.opcode = OP_CLEAR;
    end
  endtask

  initial begin : stimulus
    pblr_in_t           item;
    logic [PeriodW-1:0] periods [6];
    int                 p;
    int                 i;
    periods = '{32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, PeriodDefault};
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cur_period = PeriodDefault;
    now_cursor = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty ring, peak hold, bin closing, wraparound and long gaps, clear
    send_item(make_item(OP_STATS, '0, '0, '0));
    send_item(make_item(OP_SNAP, '0, '0, 7'd0));
    send_item(make_item(OP_SNAP, '0, '0, 7'd64));
    send_item(make_item(OP_ADD, 16'd500, 64'd1000, '0));
    send_item(make_item(OP_ADD, SampleMax, 64'd50000, '0));
    send_item(make_item(OP_ADD, 16'd0, 64'd150000, '0));
    send_item(make_item(OP_ADD, 16'd10, 64'd1000000, '0));
    send_item(make_item(OP_SNAP, '0, '0, 7'd64));
    send_item(make_item(OP_STATS, '0, '0, '0));
    // time going backwards wraps into a huge gap
    send_item(make_item(OP_ADD, 16'd7, 64'd0, '0));
    send_item(make_item(OP_ADD, SampleMax, 64'hFFFF_FFFF_FFFF_FFFF, '0));
    send_item(make_item(OP_SNAP, '0, '0, 7'd5));
    send_item(make_item(OP_SNAP, '0, '0, 7'd1));
    send_item(make_item(OP_SNAP, '0, '0, 7'd64));
    send_item(make_item(OP_STATS, '0, '0, '0));
    send_item(make_item(OP_CLEAR, '0, '0, '0));
    send_item(make_item(OP_STATS, '0, '0, '0));
    send_item(make_item(OP_SNAP, '0, '0, 7'd3));
    send_item(make_item(OP_ADD, 16'd1234, 64'hFFFF_FFFF_FFFF_FFFF, '0));
    send_item(make_item(OP_ADD, 16'd1, 64'd0, '0));
    send_item(make_item(OP_ADD, 16'd2, 64'd200000, '0));
    send_item(make_item(OP_SNAP, '0, '0, 7'd64));
    send_item(make_item(OP_STATS, '0, '0, '0));
    drain();

    for (p = 0; p < 6; p++) begin
      if (p == 4) periods[p] = $urandom;
      if (p == 5) calm <= 1'b1;
      write_period(periods[p]);
      for (i = 0; i < ItemsPerPhase; i++) begin
        if (p == 1 && i == 5) hold_seq <= hold_seq + 1;
        if (p == 2 && i == 17) drain();
        next_random(item);
        send_item(item);
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("peak_binned_latency_ring: match");
    end else begin
      $display("peak_binned_latency_ring: mismatch");
    end
    $finish;
  end

endmodule
